// File: rtl/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types, codes and controller/datapath interface structs for the
// stack arithmetic machine.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

    localparam int WORD_W          = 64;
    localparam int OP_W            = 3;
    localparam int ST_W            = 3;
    localparam int DEPTH_W         = 5;
    localparam int DEF_STACK_DEPTH = 16;

    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    localparam t_op OP_PUSH = 3'd0;
    localparam t_op OP_ADD  = 3'd1;
    localparam t_op OP_SUB  = 3'd2;
    localparam t_op OP_MUL  = 3'd3;
    localparam t_op OP_DIV  = 3'd4;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_UNDERFLOW = 3'd1;
    localparam t_status ST_OVERFLOW  = 3'd2;
    localparam t_status ST_DIVZERO   = 3'd3;
    localparam t_status ST_DIVOVF    = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_in;
        logic    rd_issue;
        logic    add_sub;
        logic    mul_start;
        logic    div_start;
        logic    commit;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic few;
        logic div_zero;
        logic div_ovf;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    function automatic logic is_arith(t_op op);
        return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

`default_nettype wire

// File: rtl/sam_div.sv
// ----------------------------------------------------------------------------
// sam_div
// Radix-2 restoring signed divider, truncating toward zero. One quotient
// bit per cycle on magnitudes, then a sign-correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_div import sam_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [WORD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic             r_neg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W+1:0] trial;

    always_comb begin
        rem_sh = {r_rem, r_quo[WORD_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[WORD_W-1] ? -i_dividend : i_dividend;
            r_dvs <= i_divisor[WORD_W-1] ? -i_divisor : i_divisor;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            // keep the partial remainder when the trial subtract borrows
            if (trial[WORD_W+1]) begin
                r_rem <= rem_sh[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end else begin
                r_rem <= trial[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end
        end else if (r_fix) begin
            r_quo <= r_neg ? -r_quo : r_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: rtl/sam_dpath.sv
// ----------------------------------------------------------------------------
// sam_dpath
// Stack memory, top-of-stack cache, depth counter, add/subtract, a shared
// 32x32 multiplier for wrapping products, the divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_dpath import sam_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire logic [OP_W-1:0]          i_opcode,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    input  wire logic                     i_stall,
    output logic                          o_valid,
    output logic [ST_W-1:0]               o_status,
    output logic signed [WORD_W-1:0]      o_top_value,
    output logic [DEPTH_W-1:0]            o_depth
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int HALF  = WORD_W / 2;

    localparam logic [2:0] MS_IDLE = 3'd0;
    localparam logic [2:0] MS_P0   = 3'd1;
    localparam logic [2:0] MS_P1   = 3'd2;
    localparam logic [2:0] MS_P2   = 3'd3;
    localparam logic [2:0] MS_ACC  = 3'd4;

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_top;
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_res;
    t_op               r_op;
    logic [WORD_W-1:0] r_val;
    logic [WORD_W-1:0] r_ma;
    logic [WORD_W-1:0] r_mb;
    logic [WORD_W-1:0] r_prod;
    logic [2:0]        r_mstep;
    logic              r_out_valid;
    t_status           r_o_status;
    logic [WORD_W-1:0] r_o_top;
    logic [DEPTH_W-1:0] r_o_depth;

    logic [CNT_W-1:0]  sub2;
    logic [AW-1:0]     idx_a;
    logic              full;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [CNT_W-1:0]  n_count;
    logic [WORD_W-1:0] n_top;
    logic [HALF-1:0]   mul_x;
    logic [HALF-1:0]   mul_y;
    logic [WORD_W-1:0] mul_prod;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;

    assign sub2  = r_count - CNT_W'(2);
    assign idx_a = sub2[AW-1:0];
    assign full  = r_count >= CNT_W'(STACK_DEPTH);

    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_op;
        o_stat.full     = full;
        o_stat.few      = r_count < CNT_W'(2);
        o_stat.div_zero = r_top == '0;
        o_stat.div_ovf  = (r_rd == WORD_MIN) && (r_top == '1);
        o_stat.mul_done = r_mstep == MS_ACC;
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    // next stack state when the pending transaction commits
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = r_val;
        n_count = r_count;
        n_top   = r_top;
        if (i_cmd.status == ST_OK) begin
            if (r_op == OP_PUSH) begin
                wr_en   = 1'b1;
                n_count = r_count + 1'b1;
                n_top   = r_val;
            end else if (is_arith(r_op)) begin
                wr_en   = 1'b1;
                wr_addr = idx_a;
                wr_data = r_res;
                n_count = r_count - 1'b1;
                n_top   = r_res;
            end
        end
    end

    // low word of a 64x64 product: lo*lo + ((lo*hi + hi*lo) << 32)
    always_comb begin
        unique case (r_mstep)
            MS_P0: begin
                mul_x = r_ma[HALF-1:0];
                mul_y = r_mb[HALF-1:0];
            end
            MS_P1: begin
                mul_x = r_ma[HALF-1:0];
                mul_y = r_mb[WORD_W-1:HALF];
            end
            MS_P2: begin
                mul_x = r_ma[WORD_W-1:HALF];
                mul_y = r_mb[HALF-1:0];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_prod = {{HALF{1'b0}}, mul_x} * {{HALF{1'b0}}, mul_y};
    end

    sam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mstep     <= MS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
            if (i_cmd.mul_start) begin
                r_mstep <= MS_P0;
            end else if (r_mstep == MS_ACC) begin
                r_mstep <= MS_IDLE;
            end else if (r_mstep != MS_IDLE) begin
                r_mstep <= r_mstep + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd <= r_mem[idx_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_opcode;
            r_val <= i_push_value;
        end
        if (i_cmd.commit) begin
            r_top       <= n_top;
            r_o_status  <= i_cmd.status;
            r_o_top     <= (n_count == '0) ? '0 : n_top;
            r_o_depth   <= DEPTH_W'(n_count);
        end
        if (i_cmd.mul_start) begin
            r_ma <= r_rd;
            r_mb <= r_top;
        end
        r_prod <= mul_prod;
        // hold the result when no unit is producing one
        if (i_cmd.add_sub) begin
            r_res <= (r_op == OP_SUB) ? (r_rd - r_top) : (r_rd + r_top);
        end else if (r_mstep == MS_P1) begin
            r_res <= r_prod;
        end else if ((r_mstep == MS_P2) || (r_mstep == MS_ACC)) begin
            r_res <= r_res + {r_prod[HALF-1:0], {HALF{1'b0}}};
        end else if (div_done) begin
            r_res <= div_quo;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_o_status;
    assign o_top_value = r_o_top;
    assign o_depth     = r_o_depth;

endmodule

`default_nettype wire

// File: rtl/sam_ctrl.sv
// ----------------------------------------------------------------------------
// sam_ctrl
// Sequencer: decodes one transaction, orders the stack read, the arithmetic
// unit and the commit, and picks the status code.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_ctrl import sam_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state  r_state;
    t_status r_status;

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE:   o_cmd.load_in  = i_valid;
            S_DECODE: o_cmd.rd_issue = is_arith(i_stat.op) && !i_stat.few;
            S_FETCH: begin
                o_cmd.add_sub   = (i_stat.op == OP_ADD) || (i_stat.op == OP_SUB);
                o_cmd.mul_start = i_stat.op == OP_MUL;
                o_cmd.div_start = (i_stat.op == OP_DIV) && !i_stat.div_zero
                                  && !i_stat.div_ovf;
            end
            S_COMMIT: o_cmd.commit = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_stall = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_status <= ST_OK;
                    r_state  <= S_COMMIT;
                    priority if (i_stat.op == OP_PUSH) begin
                        if (i_stat.full) begin
                            r_status <= ST_OVERFLOW;
                        end
                    end else if (is_arith(i_stat.op)) begin
                        if (i_stat.few) begin
                            r_status <= ST_UNDERFLOW;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                S_FETCH: begin
                    r_state <= S_COMMIT;
                    priority if (i_stat.op == OP_MUL) begin
                        r_state <= S_MUL;
                    end else if (i_stat.op == OP_DIV) begin
                        priority if (i_stat.div_zero) begin
                            r_status <= ST_DIVZERO;
                        end else if (i_stat.div_ovf) begin
                            r_status <= ST_DIVOVF;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_COMMIT;
                    end
                end
                S_MUL: begin
                    if (i_stat.mul_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/stack_arithmetic_machine.sv
// ----------------------------------------------------------------------------
// stack_arithmetic_machine
// Bounded RPN stack of signed 64-bit words: push, add, subtract, multiply,
// divide, one result per transaction with status, new top and depth.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. A push, an unused opcode or an
// underflow/overflow goes from decode straight to commit; add, subtract and
// a divide error pass through the fetch state first; multiply then forms
// three 32x32 partial products through one shared multiplier, and divide
// waits for the radix-2 divider that retires one quotient bit per cycle plus
// a sign fix. The next transaction is taken in the cycle after the result
// register loads, even while that result is still stalled. The top of stack
// is cached in a register, so each arithmetic operation needs one stack read.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_arithmetic_machine import sam_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [OP_W-1:0]          i_opcode,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [ST_W-1:0]               o_status,
    output logic signed [WORD_W-1:0]      o_top_value,
    output logic [DEPTH_W-1:0]            o_depth
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sam_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth)
    );

    // commit never overwrites a result that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || !i_stall))
        else $error("commit while result register busy");

    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction taken while one is in flight");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    a_div_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_done |-> o_stall)
        else $error("divider finished with no transaction in flight");

endmodule

`default_nettype wire

// File: bench/stack_arithmetic_machine_test.sv
// ----------------------------------------------------------------------------
// stack_arithmetic_machine_test
// Self-checking bench for the RPN stack calculator. A table of directed
// operations (empty and full stack, divide by zero, minimum over minus one,
// unused opcodes, extreme words) runs first, then a few hundred random
// operations built mostly as well-formed expressions. Each output is checked
// field by field against the table's given result or a local stack model.
// The sender bursts and idles, the receiver stalls on a shifting pattern and
// once holds off long enough to back the block up.
// ----------------------------------------------------------------------------

module stack_arithmetic_machine_test import sam_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
    localparam int RANDOM_ITEMS = 450;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 120;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_LIMIT  = 40;

    localparam t_op OP_SPARE5 = 3'd5;
    localparam t_op OP_SPARE7 = 3'd7;
    localparam t_op OP_SPARE6 = 3'd6;

    localparam logic [WORD_W-1:0] WORD_MAX     = ~WORD_MIN;
    localparam logic [WORD_W-1:0] WORD_NEG_ONE = '1;

    typedef struct packed {
        logic [DEPTH_W-1:0]                  count;
        logic [STACK_DEPTH-1:0][WORD_W-1:0]  word;
    } t_stack;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
    } t_result;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] value;
        logic              typed;
        t_result           given;
    } t_op_item;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] value;
        logic [4:0]        reps;
        logic              typed;
        t_result           given;
    } t_dir_row;

    typedef enum logic [2:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE,
        STALL_SPARSE
    } t_stall_mode;

    localparam t_result UNTYPED = '0;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic [OP_W-1:0]          i_opcode     = '0;
    logic signed [WORD_W-1:0] i_push_value = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic [ST_W-1:0]          o_status;
    logic signed [WORD_W-1:0] o_top_value;
    logic [DEPTH_W-1:0]       o_depth;

    stack_arithmetic_machine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth)
    );

    always #5 i_clk = ~i_clk;

    t_stack     plan_stack;
    t_stack     shadow_stack;
    t_op_item   op_queue[$];
    t_result    pending_results[$];
    t_dir_row   directed_rows[23];

    logic       cur_typed = 1'b0;
    t_result    cur_given = '0;
    int         mismatches = 0;
    int         results_seen = 0;

    // Model of the block: apply one operation to a stack, return the result
    task automatic stack_step(inout t_stack st, input t_op op,
                              input logic [WORD_W-1:0] value, output t_result res);
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic [WORD_W-1:0]        r;
        res.status = ST_OK;
        r = '0;
        if (op == OP_PUSH) begin
            if (st.count >= STACK_DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                st.word[st.count] = value;
                st.count = st.count + 1'b1;
            end
        end else if (op <= OP_DIV) begin
            if (st.count < 2) begin
                res.status = ST_UNDERFLOW;
            end else begin
                b = st.word[st.count - 1'b1];
                a = st.word[st.count - 2'd2];
                case (op)
                    OP_ADD: r = a + b;
                    OP_SUB: r = a - b;
                    OP_MUL: r = a * b;
                    default: begin
                        if (b == 0) begin
                            res.status = ST_DIVZERO;
                        end else if (a == WORD_MIN && b == WORD_NEG_ONE) begin
                            res.status = ST_DIVOVF;
                        end else begin
                            r = a / b;
                        end
                    end
                endcase
                if (res.status == ST_OK) begin
                    st.count = st.count - 1'b1;
                    st.word[st.count - 1'b1] = r;
                end
            end
        end
        res.top   = (st.count != 0) ? st.word[st.count - 1'b1] : '0;
        res.depth = st.count;
    endtask

    // Queue one operation, tracking the stack it will see
    task automatic plan_item(input t_op op, input logic [WORD_W-1:0] value,
                             input logic typed, input t_result given);
        t_result dummy;
        stack_step(plan_stack, op, value, dummy);
        op_queue.push_back('{op, value, typed, given});
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, w};
            4, 5:       return {32'd0, $urandom_range(0, 40)} - 64'd20;
            6:          return WORD_MIN;
            7:          return WORD_MAX;
            8:          return {32'd0, $urandom_range(0, 2)} - 64'd1;
            default:    return {{32{w[31]}}, w};
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %0t: %s got %h expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Sender: bursts of transactions separated by random gaps
    int       burst_left = 0;
    int       gap_left   = 0;
    t_op_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (op_queue.size() != 0) begin
                next_item = op_queue.pop_front();
                i_opcode     <= next_item.op;
                i_push_value <= next_item.value;
                cur_typed    <= next_item.typed;
                cur_given    <= next_item.given;
                i_valid      <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(0, 11);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long hold-off: count it here, once enough results have come out
    logic long_hold   = 1'b0;
    int   hold_cycles = 0;
    logic hold_done   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold   <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                long_hold <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            long_hold   <= 1'b1;
            hold_cycles <= LONG_HOLD;
            hold_done   <= 1'b1;
        end
    end

    // Receiver: stall pattern whose mode is redrawn at random
    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_cycles = 0;
    logic [3:0]  stall_tick  = '0;
    logic        stall_now;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(STALL_NONE, STALL_SPARSE));
                mode_cycles <= $urandom_range(20, 120);
            end else begin
                mode_cycles <= mode_cycles - 1;
            end
            stall_tick <= (stall_tick == 4'd4) ? 4'd0 : stall_tick + 1'b1;
            case (stall_mode)
                STALL_LIGHT:     stall_now = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:     stall_now = ($urandom_range(0, 9) < 6);
                STALL_ALTERNATE: stall_now = stall_tick[0];
                STALL_SPARSE:    stall_now = (stall_tick == 4'd0);
                default:         stall_now = 1'b0;
            endcase
            i_stall <= long_hold || stall_now;
        end
    end

    // Predict on every accepted transaction, check every delivered result
    t_result predicted;
    t_result oldest;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                stack_step(shadow_stack, t_op'(i_opcode), i_push_value, predicted);
                pending_results.push_back(cur_typed ? cur_given : predicted);
            end
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, status", WORD_W'(o_status), '0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_status !== oldest.status)
                        report_mismatch("status", WORD_W'(o_status),
                                        WORD_W'(oldest.status));
                    if (o_top_value !== oldest.top)
                        report_mismatch("top_value", o_top_value, oldest.top);
                    if (o_depth !== oldest.depth)
                        report_mismatch("depth", WORD_W'(o_depth), WORD_W'(oldest.depth));
                end
            end
        end
    end

    initial begin
        int          n;
        int          k;
        int          kind;
        t_op         op;

        plan_stack   = '0;
        shadow_stack = '0;

        directed_rows = '{
            '{OP_ADD,    64'd0,        5'd1,  1'b1, '{ST_UNDERFLOW, 64'd0, 5'd0}},
            '{OP_SPARE7, WORD_NEG_ONE, 5'd1,  1'b1, '{ST_OK, 64'd0, 5'd0}},
            '{OP_PUSH,   WORD_MAX,     5'd1,  1'b1, '{ST_OK, WORD_MAX, 5'd1}},
            '{OP_DIV,    64'd0,        5'd1,  1'b1, '{ST_UNDERFLOW, WORD_MAX, 5'd1}},
            '{OP_PUSH,   WORD_MIN,     5'd1,  1'b1, '{ST_OK, WORD_MIN, 5'd2}},
            '{OP_ADD,    64'd0,        5'd1,  1'b0, UNTYPED},
            '{OP_PUSH,   64'd0,        5'd1,  1'b1, '{ST_OK, 64'd0, 5'd2}},
            '{OP_DIV,    64'd0,        5'd1,  1'b1, '{ST_DIVZERO, 64'd0, 5'd2}},
            '{OP_SUB,    64'd0,        5'd1,  1'b0, UNTYPED},
            '{OP_PUSH,   WORD_MIN,     5'd1,  1'b1, '{ST_OK, WORD_MIN, 5'd2}},
            '{OP_PUSH,   WORD_NEG_ONE, 5'd1,  1'b1, '{ST_OK, WORD_NEG_ONE, 5'd3}},
            '{OP_DIV,    64'd0,        5'd1,  1'b1, '{ST_DIVOVF, WORD_NEG_ONE, 5'd3}},
            '{OP_MUL,    64'd0,        5'd1,  1'b0, UNTYPED},
            '{OP_PUSH,   64'd7,        5'd1,  1'b1, '{ST_OK, 64'd7, 5'd3}},
            '{OP_DIV,    64'd0,        5'd1,  1'b0, UNTYPED},
            '{OP_PUSH,   -64'sd3,      5'd1,  1'b1, '{ST_OK, -64'sd3, 5'd3}},
            '{OP_DIV,    64'd0,        5'd1,  1'b0, UNTYPED},
            '{OP_SPARE5, {32{2'b01}},  5'd1,  1'b0, UNTYPED},
            '{OP_SPARE6, {32{2'b10}},  5'd1,  1'b0, UNTYPED},
            '{OP_PUSH,   {32{2'b01}},  5'd13, 1'b0, UNTYPED},
            '{OP_PUSH,   {32{2'b10}},  5'd1,  1'b1, '{ST_OK, {32{2'b10}}, 5'd16}},
            '{OP_PUSH,   64'd1,        5'd1,  1'b1, '{ST_OVERFLOW, {32{2'b10}}, 5'd16}},
            '{OP_SUB,    64'd0,        5'd1,  1'b0, UNTYPED}
        };
        foreach (directed_rows[i])
            for (k = 0; k < directed_rows[i].reps; k++)
                plan_item(directed_rows[i].op, directed_rows[i].value,
                          directed_rows[i].typed, directed_rows[i].given);

        // Mostly well-formed expressions; some noise and forced error sequences
        n = 0;
        while (n < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 4) begin
                plan_item(t_op'($urandom_range(OP_SPARE5, OP_SPARE7)), pick_value(), 1'b0,
                          UNTYPED);
                n += 1;
            end else if (kind < 8) begin
                plan_item(OP_PUSH, WORD_MIN, 1'b0, UNTYPED);
                plan_item(OP_PUSH, WORD_NEG_ONE, 1'b0, UNTYPED);
                plan_item(OP_DIV, pick_value(), 1'b0, UNTYPED);
                n += 3;
            end else if (kind < 12) begin
                plan_item(OP_PUSH, 64'd0, 1'b0, UNTYPED);
                plan_item(OP_DIV, pick_value(), 1'b0, UNTYPED);
                n += 2;
            end else if (kind < 15) begin
                // push run: often reaches the full stack
                for (k = $urandom_range(4, 18); k > 0; k--) begin
                    plan_item(OP_PUSH, pick_value(), 1'b0, UNTYPED);
                    n += 1;
                end
            end else if (kind < 18) begin
                plan_item(t_op'($urandom_range(OP_ADD, OP_DIV)), pick_value(), 1'b0,
                          UNTYPED);
                n += 1;
            end else begin
                if (plan_stack.count < 2 ||
                    (plan_stack.count < STACK_DEPTH && $urandom_range(0, 9) < 4))
                    op = OP_PUSH;
                else
                    op = t_op'($urandom_range(OP_ADD, OP_DIV));
                plan_item(op, pick_value(), 1'b0, UNTYPED);
                n += 1;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (op_queue.size() != 0 || i_valid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
